// File: design/stsum_pkg.sv
// Shared types and constants for the segment tree range-sum block.
// No dependencies; every other design file imports this package.
package stsum_pkg;

  // Tree geometry
  localparam int unsigned MAX_ELEMENTS = 1024;
  localparam int unsigned NODE_COUNT   = 2 * MAX_ELEMENTS;
  localparam int unsigned ADDR_W       = $clog2(NODE_COUNT);

  // Field widths
  localparam int unsigned IDX_W  = 11;
  localparam int unsigned DATA_W = 64;

  localparam logic [IDX_W-1:0] ACTIVE_SIZE_RST = IDX_W'(1024);

  typedef logic [ADDR_W-1:0]        node_addr_t;
  typedef logic [DATA_W-1:0]        node_data_t;
  typedef logic [IDX_W-1:0]         idx_t;

  // Operation codes
  typedef enum logic {
    OP_SET   = 1'b0,
    OP_QUERY = 1'b1
  } op_e;

endpackage

// File: design/stsum_req_if.sv
// Request channel: one set or query transaction per valid/ready handshake.
// Depends on stsum_pkg.
interface stsum_req_if;
  import stsum_pkg::*;

  logic               valid;
  logic               ready;
  op_e                op;
  idx_t               position;
  logic signed [DATA_W-1:0] new_value;
  idx_t               left_bound;
  idx_t               right_bound;

  modport source (
    output valid, op, position, new_value, left_bound, right_bound,
    input  ready
  );

  modport sink (
    input  valid, op, position, new_value, left_bound, right_bound,
    output ready
  );
endinterface

// File: design/stsum_rsp_if.sv
// Response channel: one range sum per valid/ready handshake.
// Depends on stsum_pkg.
interface stsum_rsp_if;
  import stsum_pkg::*;

  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] range_sum;

  modport source (
    output valid, range_sum,
    input  ready
  );

  modport sink (
    input  valid, range_sum,
    output ready
  );
endinterface

// File: design/segment_tree_range_sum.sv
// Segment tree range sum: point set and closed-interval sum over 64-bit words.
// Set: leaf write, then one sibling read and one parent write per level.
// Query: up to two node reads per tree level on the one read port.
// One transaction in flight; the result sits in an output register until taken.
// Reset: node store cleared by a pass over all 2048 nodes (no request taken meanwhile);
// active_size returns to 1024 at once.
module segment_tree_range_sum (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_we_i,
  input  logic [stsum_pkg::IDX_W-1:0] cfg_wdata_i,
  stsum_req_if.sink              req_i,
  stsum_rsp_if.source            rsp_o
);
  import stsum_pkg::*;

  localparam int unsigned PTR_W = ADDR_W + 1;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SET_RD,
    ST_SET_WR,
    ST_Q_TEST,
    ST_Q_RDA,
    ST_Q_B,
    ST_Q_RDB
  } state_e;

  // Finished sum waiting in acc_q for the output register
  typedef enum logic {
    RES_NONE,
    RES_PEND
  } res_e;

  state_e             state_q, state_d;
  res_e               res_q, res_d;
  idx_t               active_q;
  node_addr_t         ctr_q, ctr_d;
  node_addr_t         k_q, k_d;
  node_data_t         cur_q, cur_d;
  logic [PTR_W-1:0]   a_q, a_d, b_q, b_d;
  node_data_t         acc_q, acc_d;
  logic               out_valid_q, out_valid_d;
  node_data_t         out_data_q, out_data_d;

  logic               mem_we;
  node_addr_t         mem_waddr;
  node_data_t         mem_wdata;
  node_addr_t         mem_raddr;
  node_data_t         mem_rdata;

  idx_t               size_eff;
  idx_t               lo_clip, hi_clip;
  logic               pos_ok;
  logic               req_acc;
  logic [PTR_W-1:0]   b_dec;
  node_data_t         set_sum;

  stsum_node_ram u_node_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  // Clip the register and the query bounds to the tree
  always_comb begin
    size_eff = (active_q > IDX_W'(MAX_ELEMENTS)) ? IDX_W'(MAX_ELEMENTS) : active_q;
    lo_clip  = (req_i.left_bound == '0) ? IDX_W'(1) : req_i.left_bound;
    hi_clip  = (req_i.right_bound > size_eff) ? size_eff : req_i.right_bound;
    pos_ok   = (req_i.position != '0) && (req_i.position <= size_eff);
  end

  assign req_i.ready     = (state_q == ST_IDLE) && (res_q == RES_NONE);
  assign req_acc         = req_i.valid && req_i.ready;
  assign rsp_o.valid     = out_valid_q;
  assign rsp_o.range_sum = out_data_q;
  assign b_dec           = b_q - PTR_W'(1);
  assign set_sum         = cur_q + mem_rdata;

  // Sequencer: clear pass, leaf-to-root update, bottom-up interval walk
  always_comb begin
    state_d     = state_q;
    res_d       = res_q;
    ctr_d       = ctr_q;
    k_d         = k_q;
    cur_d       = cur_q;
    a_d         = a_q;
    b_d         = b_q;
    acc_d       = acc_q;
    out_valid_d = out_valid_q;
    out_data_d  = out_data_q;
    mem_we      = 1'b0;
    mem_waddr   = k_q;
    mem_wdata   = cur_q;
    mem_raddr   = '0;

    // Drop the result once taken
    if (out_valid_q && rsp_o.ready) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = ctr_q;
        mem_wdata = '0;
        ctr_d     = ctr_q + ADDR_W'(1);
        if (ctr_q == node_addr_t'(NODE_COUNT - 1)) begin
          state_d = ST_IDLE;
        end
      end

      ST_IDLE: begin
        // Hand a finished sum to the output register when it is free
        if (res_q == RES_PEND && !out_valid_d) begin
          out_valid_d = 1'b1;
          out_data_d  = acc_q;
          res_d       = RES_NONE;
        end
        if (req_acc) begin
          if (req_i.op == OP_SET) begin
            if (pos_ok) begin
              mem_we    = 1'b1;
              mem_waddr = ADDR_W'(MAX_ELEMENTS) + ADDR_W'(req_i.position) - ADDR_W'(1);
              mem_wdata = req_i.new_value;
              k_d       = mem_waddr;
              cur_d     = req_i.new_value;
              state_d   = ST_SET_RD;
            end
          end else begin
            acc_d = '0;
            if (lo_clip <= hi_clip) begin
              a_d     = PTR_W'(MAX_ELEMENTS) + PTR_W'(lo_clip) - PTR_W'(1);
              b_d     = PTR_W'(MAX_ELEMENTS) + PTR_W'(hi_clip);
              state_d = ST_Q_TEST;
            end else begin
              res_d = RES_PEND;
            end
          end
        end
      end

      ST_SET_RD: begin
        mem_raddr = {k_q[ADDR_W-1:1], ~k_q[0]};
        state_d   = ST_SET_WR;
      end

      ST_SET_WR: begin
        mem_we    = 1'b1;
        mem_waddr = k_q >> 1;
        mem_wdata = set_sum;
        cur_d     = set_sum;
        k_d       = k_q >> 1;
        state_d   = (k_q[ADDR_W-1:2] != '0) ? ST_SET_RD : ST_IDLE;
      end

      ST_Q_TEST: begin
        if (a_q < b_q) begin
          if (a_q[0]) begin
            mem_raddr = a_q[ADDR_W-1:0];
            state_d   = ST_Q_RDA;
          end else begin
            state_d = ST_Q_B;
          end
        end else begin
          res_d   = RES_PEND;
          state_d = ST_IDLE;
        end
      end

      ST_Q_RDA: begin
        acc_d   = acc_q + mem_rdata;
        a_d     = a_q + PTR_W'(1);
        state_d = ST_Q_B;
      end

      ST_Q_B: begin
        if (b_q[0]) begin
          mem_raddr = b_dec[ADDR_W-1:0];
          b_d       = b_dec;
          state_d   = ST_Q_RDB;
        end else begin
          a_d     = a_q >> 1;
          b_d     = b_q >> 1;
          state_d = ST_Q_TEST;
        end
      end

      ST_Q_RDB: begin
        acc_d   = acc_q + mem_rdata;
        a_d     = a_q >> 1;
        b_d     = b_q >> 1;
        state_d = ST_Q_TEST;
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Hold state, clear counter, output valid and the active size register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      res_q       <= RES_NONE;
      ctr_q       <= '0;
      out_valid_q <= 1'b0;
      active_q    <= ACTIVE_SIZE_RST;
    end else begin
      state_q     <= state_d;
      res_q       <= res_d;
      ctr_q       <= ctr_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        active_q <= cfg_wdata_i;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    k_q        <= k_d;
    cur_q      <= cur_d;
    a_q        <= a_d;
    b_q        <= b_d;
    acc_q      <= acc_d;
    out_data_q <= out_data_d;
  end
endmodule

// File: design/stsum_node_ram.sv
// Node-sum storage: one write port, one read port, registered read data.
// Depends on stsum_pkg for geometry and word types.
module stsum_node_ram (
  input  logic                   clk_i,
  input  logic                   we_i,
  input  stsum_pkg::node_addr_t  waddr_i,
  input  stsum_pkg::node_data_t  wdata_i,
  input  stsum_pkg::node_addr_t  raddr_i,
  output stsum_pkg::node_data_t  rdata_o
);
  import stsum_pkg::*;

  node_data_t mem [NODE_COUNT];
  node_data_t rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // Read port, registered read data
  always_ff @(posedge clk_i) begin
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;
endmodule
